// File: rtl/fela_pkg.sv
`default_nettype none
package fela_pkg;

	localparam int unsigned CLUSTER_W = 28;
	localparam int unsigned WINDOW_W  = 32;
	localparam int unsigned SECTOR_W  = 32;
	localparam int unsigned OFFSET_W  = 12;
	localparam int unsigned FDS_W     = 36;
	localparam int unsigned POS_W     = 30;
	localparam int unsigned SECIDX_W  = 21;
	localparam int unsigned REG_IDX_W = 3;
	localparam int unsigned REG_DAT_W = 32;

	typedef enum logic [1:0] {
		FT_FAT12 = 2'd0,
		FT_FAT16 = 2'd1,
		FT_FAT32 = 2'd2
	} fat_type_t;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_FAT_TYPE      = 3'd0,
		REG_SECTOR_LOG2   = 3'd1,
		REG_RESERVED      = 3'd2,
		REG_SEC_PER_CLUS  = 3'd3,
		REG_DATA_START    = 3'd4,
		REG_FAT_SIZE      = 3'd5
	} reg_idx_t;

	localparam logic [11:0] MASK12      = 12'hFFF;
	localparam logic [27:0] FAT12_EOC   = 28'h0000FF8;
	localparam logic [27:0] FAT16_EOC   = 28'h000FFF8;
	localparam logic [27:0] FAT32_EOC   = 28'hFFFFFF8;
	localparam logic [27:0] FAT12_BAD   = 28'h0000FF7;
	localparam logic [27:0] FAT16_BAD   = 28'h000FFF7;
	localparam logic [27:0] FAT32_BAD   = 28'hFFFFFF7;

	localparam logic [3:0] LOG2_MIN = 4'd9;
	localparam logic [3:0] LOG2_MAX = 4'd12;

endpackage
`default_nettype wire

// File: rtl/fela_req_if.sv
`default_nettype none
interface fela_req_if;
	logic                               valid;
	logic                               ready;
	logic [fela_pkg::CLUSTER_W-1:0]     cluster_number;
	logic [fela_pkg::WINDOW_W-1:0]      fat_window;
	logic [fela_pkg::CLUSTER_W-1:0]     new_entry_value;

	modport source (
		output valid, cluster_number, fat_window, new_entry_value,
		input  ready
	);
	modport sink (
		input  valid, cluster_number, fat_window, new_entry_value,
		output ready
	);
endinterface
`default_nettype wire

// File: rtl/fela_rsp_if.sv
`default_nettype none
interface fela_rsp_if;
	logic                           valid;
	logic                           ready;
	logic [fela_pkg::SECTOR_W-1:0]  fat_sector;
	logic [fela_pkg::OFFSET_W-1:0]  entry_byte_offset;
	logic                           spans_next_sector;
	logic [fela_pkg::CLUSTER_W-1:0] entry_value;
	logic [fela_pkg::WINDOW_W-1:0]  merged_window;
	logic                           end_of_chain;
	logic                           bad_cluster;
	logic                           free_cluster;
	logic [fela_pkg::FDS_W-1:0]     first_data_sector;

	modport source (
		output valid, fat_sector, entry_byte_offset, spans_next_sector, entry_value,
		       merged_window, end_of_chain, bad_cluster, free_cluster, first_data_sector,
		input  ready
	);
	modport sink (
		input  valid, fat_sector, entry_byte_offset, spans_next_sector, entry_value,
		       merged_window, end_of_chain, bad_cluster, free_cluster, first_data_sector,
		output ready
	);
endinterface
`default_nettype wire

// File: rtl/fela_cfg_if.sv
`default_nettype none
interface fela_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [fela_pkg::REG_IDX_W-1:0] index;
	logic [fela_pkg::REG_DAT_W-1:0] data;

	modport source (
		output valid, index, data,
		input  ready
	);
	modport sink (
		input  valid, index, data,
		output ready
	);
endinterface
`default_nettype wire

// File: rtl/fat_entry_locate_and_access_top.sv
`default_nettype none
// FAT12/16/32 entry locator: one result per item, three register stages, so a result
// is offered once its item reaches stage three; one item is taken every cycle while
// the result side keeps up. Stage one forms the entry byte position and cluster minus
// two, stage two splits the position into sector and offset, decodes and merges the
// window and multiplies by sectors per cluster, stage three adds the data start and
// checks for a FAT12 entry crossing a sector. Input ready drops only when all three
// stages hold items and the result is not taken. Registers are to be written only
// when no item is in flight; the block does not enforce this. The write port is
// always ready.
module fat_entry_locate_and_access_top (
	input  wire logic  clk,
	input  wire logic  arst_n,
	fela_cfg_if.sink   cfg,
	fela_req_if.sink   req,
	fela_rsp_if.source rsp
);

	// configuration registers
	logic [1:0]  fat_type_q;
	logic [3:0]  sector_log2_q;
	logic [15:0] reserved_q;
	logic [7:0]  spc_q;
	logic [31:0] data_start_q;
	logic [31:0] fat_size_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fat_type_q    <= 2'd0;
			sector_log2_q <= 4'd9;
			reserved_q    <= 16'd1;
			spc_q         <= 8'd1;
			data_start_q  <= 32'd0;
			fat_size_q    <= 32'd1;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				fela_pkg::REG_FAT_TYPE:     fat_type_q    <= cfg.data[1:0];
				fela_pkg::REG_SECTOR_LOG2:  sector_log2_q <= cfg.data[3:0];
				fela_pkg::REG_RESERVED:     reserved_q    <= cfg.data[15:0];
				fela_pkg::REG_SEC_PER_CLUS: spc_q         <= cfg.data[7:0];
				fela_pkg::REG_DATA_START:   data_start_q  <= cfg.data;
				fela_pkg::REG_FAT_SIZE:     fat_size_q    <= cfg.data;
				default: ;
			endcase
		end
	end

	// flow control
	logic v_s1, v_s2, v_s3;
	logic adv_s1, adv_s2, adv_s3;

	assign adv_s3    = !v_s3 || rsp.ready;
	assign adv_s2    = !v_s2 || adv_s3;
	assign adv_s1    = !v_s1 || adv_s2;
	assign req.ready = adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (adv_s1) v_s1 <= req.valid;
			if (adv_s2) v_s2 <= v_s1;
			if (adv_s3) v_s3 <= v_s2;
		end
	end

	// stage 1: byte position, shift select, cluster minus two
	logic [fela_pkg::POS_W-1:0]     pos_d;
	logic [1:0]                     sh_d;
	logic [fela_pkg::POS_W-1:0]     pos_s1;
	logic [1:0]                     sh_s1;
	logic [1:0]                     ftype_s1;
	logic                           odd_s1;
	logic [31:0]                    win_s1;
	logic [27:0]                    nv_s1;
	logic [fela_pkg::FDS_W-1:0]     diff_s1;

	always_comb begin
		case (fat_type_q)
			fela_pkg::FT_FAT12: pos_d = {2'b00, req.cluster_number}
			                          + {3'b000, req.cluster_number[27:1]};
			fela_pkg::FT_FAT16: pos_d = {1'b0, req.cluster_number, 1'b0};
			fela_pkg::FT_FAT32: pos_d = {req.cluster_number, 2'b00};
			default:            pos_d = '0;
		endcase
		// saturate sector size into 512..4096
		if (sector_log2_q < fela_pkg::LOG2_MIN) begin
			sh_d = 2'd0;
		end else if (sector_log2_q > fela_pkg::LOG2_MAX) begin
			sh_d = 2'd3;
		end else begin
			sh_d = 2'(sector_log2_q - fela_pkg::LOG2_MIN);
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && req.valid) begin
			pos_s1   <= pos_d;
			sh_s1    <= sh_d;
			ftype_s1 <= fat_type_q;
			odd_s1   <= req.cluster_number[0];
			win_s1   <= req.fat_window;
			nv_s1    <= req.new_entry_value;
			diff_s1  <= {8'd0, req.cluster_number} - 36'd2;
		end
	end

	// stage 2: sector split, decode, merge, multiply
	logic [fela_pkg::SECIDX_W-1:0]  secidx_d;
	logic [11:0]                    offs_d;
	logic [11:0]                    omask_d;
	logic [27:0]                    ent_d;
	logic [31:0]                    merged_d;
	logic [27:0]                    eoc_lim_d;
	logic [27:0]                    bad_code_d;
	logic                           known_d;

	logic [fela_pkg::SECIDX_W-1:0]  secidx_s2;
	logic [11:0]                    offs_s2;
	logic                           last_byte_s2;
	logic                           fat12_s2;
	logic [31:0]                    sector_s2;
	logic [27:0]                    ent_s2;
	logic [31:0]                    merged_s2;
	logic                           eoc_s2;
	logic                           bad_s2;
	logic                           free_s2;
	logic [fela_pkg::FDS_W-1:0]     prod_s2;

	always_comb begin
		case (sh_s1)
			2'd0:    secidx_d = pos_s1[29:9];
			2'd1:    secidx_d = {1'b0, pos_s1[29:10]};
			2'd2:    secidx_d = {2'b00, pos_s1[29:11]};
			default: secidx_d = {3'b000, pos_s1[29:12]};
		endcase
		omask_d = 12'((13'd1 << (4'd9 + {2'b00, sh_s1})) - 13'd1);
		offs_d  = pos_s1[11:0] & omask_d;

		ent_d      = '0;
		merged_d   = win_s1;
		eoc_lim_d  = '0;
		bad_code_d = '0;
		known_d    = 1'b1;
		case (ftype_s1)
			fela_pkg::FT_FAT12: begin
				if (odd_s1) begin
					ent_d    = {16'd0, win_s1[15:4]};
					merged_d = {win_s1[31:16], nv_s1[11:0], win_s1[3:0]};
				end else begin
					ent_d    = {16'd0, win_s1[11:0] & fela_pkg::MASK12};
					merged_d = {win_s1[31:12], nv_s1[11:0]};
				end
				eoc_lim_d  = fela_pkg::FAT12_EOC;
				bad_code_d = fela_pkg::FAT12_BAD;
			end
			fela_pkg::FT_FAT16: begin
				ent_d      = {12'd0, win_s1[15:0]};
				merged_d   = {win_s1[31:16], nv_s1[15:0]};
				eoc_lim_d  = fela_pkg::FAT16_EOC;
				bad_code_d = fela_pkg::FAT16_BAD;
			end
			fela_pkg::FT_FAT32: begin
				ent_d      = win_s1[27:0];
				merged_d   = {win_s1[31:28], nv_s1};
				eoc_lim_d  = fela_pkg::FAT32_EOC;
				bad_code_d = fela_pkg::FAT32_BAD;
			end
			default: known_d = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (adv_s2 && v_s1) begin
			secidx_s2    <= secidx_d;
			offs_s2      <= offs_d;
			last_byte_s2 <= (offs_d == omask_d);
			fat12_s2     <= (ftype_s1 == fela_pkg::FT_FAT12);
			sector_s2    <= {16'd0, reserved_q} + {11'd0, secidx_d};
			ent_s2       <= ent_d;
			merged_s2    <= merged_d;
			eoc_s2       <= known_d && (ent_d >= eoc_lim_d);
			bad_s2       <= known_d && (ent_d == bad_code_d);
			free_s2      <= known_d && (ent_d == 28'd0);
			prod_s2      <= diff_s1 * {28'd0, spc_q};
		end
	end

	// stage 3: data start add, sector crossing check
	logic [31:0]                    sector_s3;
	logic [11:0]                    offs_s3;
	logic                           spans_s3;
	logic [27:0]                    ent_s3;
	logic [31:0]                    merged_s3;
	logic                           eoc_s3;
	logic                           bad_s3;
	logic                           free_s3;
	logic [fela_pkg::FDS_W-1:0]     fds_s3;

	always_ff @(posedge clk) begin
		if (adv_s3 && v_s2) begin
			sector_s3 <= sector_s2;
			offs_s3   <= offs_s2;
			spans_s3  <= fat12_s2 && last_byte_s2
			             && ({11'd0, secidx_s2} != (fat_size_q - 32'd1));
			ent_s3    <= ent_s2;
			merged_s3 <= merged_s2;
			eoc_s3    <= eoc_s2;
			bad_s3    <= bad_s2;
			free_s3   <= free_s2;
			fds_s3    <= prod_s2 + {4'd0, data_start_q};
		end
	end

	assign rsp.valid             = v_s3;
	assign rsp.fat_sector        = sector_s3;
	assign rsp.entry_byte_offset = offs_s3;
	assign rsp.spans_next_sector = spans_s3;
	assign rsp.entry_value       = ent_s3;
	assign rsp.merged_window     = merged_s3;
	assign rsp.end_of_chain      = eoc_s3;
	assign rsp.bad_cluster       = bad_s3;
	assign rsp.free_cluster      = free_s3;
	assign rsp.first_data_sector = fds_s3;

	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 |-> $onehot0({eoc_s3, bad_s3, free_s3}))
		else $error("entry classified more than once");

	a_span_at_last_byte: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s3 && spans_s3) |-> (offs_s3[8:0] == 9'h1FF))
		else $error("sector crossing flagged away from the last byte");

	a_ready_when_drained: assert property (@(posedge clk) disable iff (!arst_n)
		!v_s3 |-> req.ready)
		else $error("input stalled with an empty output stage");

	a_stall_holds_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && !adv_s2) |=> (v_s1 && $stable(pos_s1) && $stable(win_s1)))
		else $error("stage one item lost during stall");

	a_stall_holds_s3: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s3 && !rsp.ready) |=> (v_s3 && $stable(fds_s3) && $stable(merged_s3)))
		else $error("result changed while stalled");

endmodule
`default_nettype wire
